// ===== rtl/core/rrb_pkg.sv =====
// rrb_pkg: sizes, command and status codes, controller/datapath command types
// for the record ring buffer; no dependencies
`default_nettype none

package rrb_pkg;

  localparam int BUF_BYTES = 4096;   // power of two, pointers wrap by masking
  localparam int MAX_LINE  = 1024;

  localparam int PTR_W   = $clog2(BUF_BYTES);
  localparam int CNT_W   = $clog2(BUF_BYTES + 1);
  localparam int LEN_CAP = (MAX_LINE > BUF_BYTES - 3) ? BUF_BYTES - 3 : MAX_LINE;
  localparam int LEN_W   = $clog2(LEN_CAP + 4);
  localparam int SPAN_W  = 17;

  localparam logic [2:0] CMD_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_DATA   = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_REWIND = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_REJ   = 2'd3;

  localparam logic CFG_MIN_LEVEL  = 1'b0;
  localparam logic CFG_CUMULATIVE = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_REJECT,
    DP_DATA,
    DP_CLEAR,
    DP_REWIND,
    DP_EV_LO,
    DP_EV_DO,
    DP_EV_END,
    DP_HDR0,
    DP_HDR1,
    DP_HDR2,
    DP_RD_NONE,
    DP_RD_LVL,
    DP_RD_LO,
    DP_RD_HDR,
    DP_RD_BYTE,
    DP_PUSH
  } dp_op_e;

  typedef enum logic [2:0] {
    RD_OLD1,
    RD_OLD2,
    RD_WALK,
    RD_WALK1,
    RD_WALK2
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd_sel;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       record_open;
    logic       evict_need;
    logic       walk_in_record;
    logic       walk_done;
    logic       hdr_stop;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrb_if.sv =====
// rrb_in_if / rrb_out_if: valid-ready channels of the record ring buffer
// no dependencies
`default_nettype none

interface rrb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [1:0]  level;
  logic [15:0] record_length;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, level, record_length, data_byte, input ready);
  modport sink   (input valid, cmd, level, record_length, data_byte, output ready);
endinterface

interface rrb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic [1:0] out_level;
  logic       last_of_record;

  modport source (output valid, status, out_byte, out_level, last_of_record, input ready);
  modport sink   (input valid, status, out_byte, out_level, last_of_record, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrb_ctrl.sv =====
// rrb_ctrl: sequencing state machine of the record ring buffer
// depends on rrb_pkg
`default_nettype none

module rrb_ctrl
  import rrb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_ctl_t  ctl_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_EVC  = 4'd2;
  localparam logic [3:0] S_EV1  = 4'd3;
  localparam logic [3:0] S_EV2  = 4'd4;
  localparam logic [3:0] S_H0   = 4'd5;
  localparam logic [3:0] S_H1   = 4'd6;
  localparam logic [3:0] S_H2   = 4'd7;
  localparam logic [3:0] S_RDC  = 4'd8;
  localparam logic [3:0] S_R0   = 4'd9;
  localparam logic [3:0] S_R1   = 4'd10;
  localparam logic [3:0] S_R2   = 4'd11;
  localparam logic [3:0] S_RB   = 4'd12;
  localparam logic [3:0] S_RES  = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    ctl_o.op     = DP_NOP;
    ctl_o.rd_sel = RD_WALK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = DP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RES;
        unique case (stat_i.cmd)
          CMD_BEGIN: begin
            if (stat_i.record_open) ctl_o.op = DP_REJECT;
            else state_d = S_EVC;
          end
          CMD_DATA: begin
            ctl_o.op = stat_i.record_open ? DP_DATA : DP_REJECT;
          end
          CMD_READ:   state_d = S_RDC;
          CMD_CLEAR:  ctl_o.op = DP_CLEAR;
          CMD_REWIND: ctl_o.op = DP_REWIND;
          default:    ctl_o.op = DP_REJECT;
        endcase
      end
      S_EVC: begin
        if (stat_i.evict_need) begin
          ctl_o.rd_sel = RD_OLD1;
          state_d      = S_EV1;
        end else begin
          ctl_o.op = DP_EV_END;
          state_d  = S_H0;
        end
      end
      S_EV1: begin
        ctl_o.op     = DP_EV_LO;
        ctl_o.rd_sel = RD_OLD2;
        state_d      = S_EV2;
      end
      S_EV2: begin
        ctl_o.op = DP_EV_DO;
        state_d  = S_EVC;
      end
      S_H0: begin
        ctl_o.op = DP_HDR0;
        state_d  = S_H1;
      end
      S_H1: begin
        ctl_o.op = DP_HDR1;
        state_d  = S_H2;
      end
      S_H2: begin
        ctl_o.op = DP_HDR2;
        state_d  = S_RES;
      end
      S_RDC: begin
        priority if (stat_i.walk_in_record) begin
          state_d = S_RB;
        end else if (stat_i.walk_done) begin
          ctl_o.op = DP_RD_NONE;
          state_d  = S_RES;
        end else begin
          state_d = S_R0;
        end
      end
      S_R0: begin
        ctl_o.op     = DP_RD_LVL;
        ctl_o.rd_sel = RD_WALK1;
        state_d      = S_R1;
      end
      S_R1: begin
        ctl_o.op     = DP_RD_LO;
        ctl_o.rd_sel = RD_WALK2;
        state_d      = S_R2;
      end
      S_R2: begin
        ctl_o.op = DP_RD_HDR;
        state_d  = stat_i.hdr_stop ? S_RES : S_RDC;
      end
      S_RB: begin
        ctl_o.op = DP_RD_BYTE;
        state_d  = S_RES;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          ctl_o.op = DP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rrb_dpath.sv =====
// rrb_dpath: byte store, pointers, walk state, config and result registers
// depends on rrb_pkg
`default_nettype none

module rrb_dpath
  import rrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_ctl_t     ctl_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [1:0]  cfg_data_i,
  input  logic [2:0]  in_cmd_i,
  input  logic [1:0]  in_level_i,
  input  logic [15:0] in_length_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_level_o,
  output logic        out_last_o
);

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata_q;
  logic [PTR_W-1:0] rd_addr;
  logic       mem_we;
  logic [7:0] wdata;

  // latched word
  logic [2:0]  cmd_q;
  logic [1:0]  lvl_q;
  logic [15:0] len_q;
  logic [7:0]  byte_q;

  // config
  logic [1:0] min_level_q, min_level_d;
  logic       cumulative_q, cumulative_d;

  // ring state
  logic [PTR_W-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [LEN_W-1:0] wrem_q, wrem_d, open_bytes_q, open_bytes_d;
  logic             open_q, open_d, evicted_q, evicted_d;

  // walk state
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [CNT_W-1:0] wcons_q, wcons_d, wrem_walk_q, wrem_walk_d;
  logic [1:0]       wlevel_q, wlevel_d;
  logic             win_q, win_d;

  // header scratch
  logic [7:0] lo_q, lo_d;
  logic [1:0] hl_q, hl_d;

  // result and output
  logic [1:0] res_st_q, res_st_d, res_lvl_q, res_lvl_d;
  logic [7:0] res_byte_q, res_byte_d;
  logic       res_last_q, res_last_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_st_q, out_lvl_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [15:0]      len_sat;
  logic [CNT_W-1:0] used, limit, room, hclip;
  logic [CNT_W:0]   cons3;
  logic [SPAN_W-1:0] span;
  logic [15:0]      hlen_raw;
  logic             shown, out_free;

  assign len_sat  = (len_q > 16'(LEN_CAP)) ? 16'(LEN_CAP) : len_q;
  assign used     = CNT_W'(BUF_BYTES) - free_q;
  assign limit    = open_q ? ((CNT_W'(open_bytes_q) < used) ? used - CNT_W'(open_bytes_q)
                                                            : '0)
                           : used;
  assign cons3    = {1'b0, wcons_q} + (CNT_W+1)'(3);
  assign room     = limit - cons3[CNT_W-1:0];
  assign hlen_raw = {rdata_q, lo_q};
  assign hclip    = ({{(SPAN_W-16){1'b0}}, hlen_raw} > SPAN_W'(room)) ? room
                                                                      : CNT_W'(hlen_raw);
  assign span     = SPAN_W'(hlen_raw) + SPAN_W'(3);
  assign shown    = (cumulative_q && (hl_q >= min_level_q)) || (hl_q == min_level_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.cmd            = cmd_q;
    stat_o.record_open    = open_q;
    stat_o.evict_need     = (free_q < CNT_W'(len_sat) + CNT_W'(3))
                            && (free_q < CNT_W'(BUF_BYTES));
    stat_o.walk_in_record = win_q;
    stat_o.walk_done      = cons3 > {1'b0, limit};
    stat_o.hdr_stop       = shown && (hclip == '0);
    stat_o.out_free       = out_free;
  end

  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_OLD1:  rd_addr = oldest_q + PTR_W'(1);
      RD_OLD2:  rd_addr = oldest_q + PTR_W'(2);
      RD_WALK1: rd_addr = wptr_q + PTR_W'(1);
      RD_WALK2: rd_addr = wptr_q + PTR_W'(2);
      default:  rd_addr = wptr_q;
    endcase
  end

  always_comb begin
    min_level_d  = min_level_q;
    cumulative_d = cumulative_q;
    oldest_d     = oldest_q;
    newest_d     = newest_q;
    free_d       = free_q;
    wrem_d       = wrem_q;
    open_bytes_d = open_bytes_q;
    open_d       = open_q;
    evicted_d    = evicted_q;
    wptr_d       = wptr_q;
    wcons_d      = wcons_q;
    wrem_walk_d  = wrem_walk_q;
    wlevel_d     = wlevel_q;
    win_d        = win_q;
    lo_d         = lo_q;
    hl_d         = hl_q;
    res_st_d     = res_st_q;
    res_lvl_d    = res_lvl_q;
    res_byte_d   = res_byte_q;
    res_last_d   = res_last_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    mem_we       = 1'b0;
    wdata        = byte_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MIN_LEVEL:  min_level_d  = cfg_data_i;
        CFG_CUMULATIVE: cumulative_d = cfg_data_i[0];
        default: ;
      endcase
    end

    // every op that ends an item leaves an ok word unless it says otherwise
    unique case (ctl_i.op)
      DP_REJECT, DP_DATA, DP_CLEAR, DP_REWIND, DP_HDR2, DP_RD_NONE: begin
        res_st_d   = (ctl_i.op == DP_REJECT) ? ST_REJ
                   : (ctl_i.op == DP_RD_NONE) ? ST_NONE : ST_OK;
        res_lvl_d  = '0;
        res_byte_d = '0;
        res_last_d = 1'b0;
      end
      default: ;
    endcase

    unique case (ctl_i.op)
      DP_LATCH: evicted_d = 1'b0;
      DP_DATA: begin
        mem_we       = 1'b1;
        wdata        = byte_q;
        newest_d     = newest_q + PTR_W'(1);
        free_d       = (free_q != '0) ? free_q - CNT_W'(1) : free_q;
        open_bytes_d = open_bytes_q + LEN_W'(1);
        wrem_d       = wrem_q - LEN_W'(1);
        if (wrem_q == LEN_W'(1)) begin
          open_d       = 1'b0;
          open_bytes_d = '0;
        end
      end
      DP_CLEAR, DP_REWIND, DP_EV_END: begin
        if (ctl_i.op == DP_CLEAR) begin
          oldest_d     = '0;
          newest_d     = '0;
          free_d       = CNT_W'(BUF_BYTES);
          wrem_d       = '0;
          open_d       = 1'b0;
          open_bytes_d = '0;
        end
        if (ctl_i.op != DP_EV_END || evicted_q) begin
          wptr_d      = (ctl_i.op == DP_CLEAR) ? '0 : oldest_q;
          wcons_d     = '0;
          wrem_walk_d = '0;
          win_d       = 1'b0;
          wlevel_d    = '0;
        end
      end
      DP_EV_LO: lo_d = rdata_q;
      DP_EV_DO: begin
        evicted_d = 1'b1;
        if (span > SPAN_W'(used)) begin
          oldest_d = newest_q;
          free_d   = CNT_W'(BUF_BYTES);
        end else begin
          oldest_d = oldest_q + span[PTR_W-1:0];
          free_d   = free_q + span[CNT_W-1:0];
        end
      end
      DP_HDR0, DP_HDR1, DP_HDR2: begin
        mem_we   = 1'b1;
        newest_d = newest_q + PTR_W'(1);
        free_d   = (free_q != '0) ? free_q - CNT_W'(1) : free_q;
        unique case (ctl_i.op)
          DP_HDR0: wdata = {6'd0, lvl_q};
          DP_HDR1: wdata = len_sat[7:0];
          default: wdata = len_sat[15:8];
        endcase
        if (ctl_i.op == DP_HDR2) begin
          wrem_d       = len_sat[LEN_W-1:0];
          open_d       = (len_sat != '0);
          open_bytes_d = (len_sat != '0) ? LEN_W'(3) : '0;
        end
      end
      DP_RD_LVL: hl_d = rdata_q[1:0];
      DP_RD_LO:  lo_d = rdata_q;
      DP_RD_HDR: begin
        wcons_d = cons3[CNT_W-1:0];
        if (shown) begin
          wptr_d = wptr_q + PTR_W'(3);
          if (hclip == '0) begin
            res_st_d   = ST_EMPTY;
            res_lvl_d  = hl_q;
            res_byte_d = '0;
            res_last_d = 1'b1;
          end else begin
            win_d       = 1'b1;
            wrem_walk_d = hclip;
            wlevel_d    = hl_q;
          end
        end else begin
          wptr_d  = wptr_q + PTR_W'(3) + hclip[PTR_W-1:0];
          wcons_d = cons3[CNT_W-1:0] + hclip;
        end
      end
      DP_RD_BYTE: begin
        res_st_d    = ST_OK;
        res_byte_d  = rdata_q;
        res_lvl_d   = wlevel_q;
        res_last_d  = (wrem_walk_q == CNT_W'(1));
        wptr_d      = wptr_q + PTR_W'(1);
        wcons_d     = wcons_q + CNT_W'(1);
        wrem_walk_d = wrem_walk_q - CNT_W'(1);
        if (wrem_walk_q == CNT_W'(1)) win_d = 1'b0;
      end
      DP_PUSH: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[newest_q] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_LATCH) begin
      cmd_q  <= in_cmd_i;
      lvl_q  <= in_level_i;
      len_q  <= in_length_i;
      byte_q <= in_byte_i;
    end
    if (ctl_i.op == DP_PUSH) begin
      out_st_q   <= res_st_q;
      out_lvl_q  <= res_lvl_q;
      out_byte_q <= res_byte_q;
      out_last_q <= res_last_q;
    end
    lo_q       <= lo_d;
    hl_q       <= hl_d;
    res_st_q   <= res_st_d;
    res_lvl_q  <= res_lvl_d;
    res_byte_q <= res_byte_d;
    res_last_q <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q  <= '0;
      cumulative_q <= 1'b1;
      oldest_q     <= '0;
      newest_q     <= '0;
      free_q       <= CNT_W'(BUF_BYTES);
      wrem_q       <= '0;
      open_bytes_q <= '0;
      open_q       <= 1'b0;
      evicted_q    <= 1'b0;
      wptr_q       <= '0;
      wcons_q      <= '0;
      wrem_walk_q  <= '0;
      wlevel_q     <= '0;
      win_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      min_level_q  <= min_level_d;
      cumulative_q <= cumulative_d;
      oldest_q     <= oldest_d;
      newest_q     <= newest_d;
      free_q       <= free_d;
      wrem_q       <= wrem_d;
      open_bytes_q <= open_bytes_d;
      open_q       <= open_d;
      evicted_q    <= evicted_d;
      wptr_q       <= wptr_d;
      wcons_q      <= wcons_d;
      wrem_walk_q  <= wrem_walk_d;
      wlevel_q     <= wlevel_d;
      win_q        <= win_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_byte_o   = out_byte_q;
  assign out_level_o  = out_lvl_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/record_ring_buffer_with_eviction.sv =====
// record_ring_buffer_with_eviction: top level, controller plus datapath
// depends on rrb_pkg, rrb_if, rrb_ctrl, rrb_dpath
//
//   channel   dir   handshake      word
//   in_i      in    valid/ready    cmd, level, record_length, data_byte
//   out_o     out   valid/ready    status, out_byte, out_level, last_of_record
//   cfg       in    cfg_we_i only  cfg_addr_i selects min_level / cumulative
//
// one command word is in flight at a time; the result sits in an output
// register so the next word is taken while it waits
// clear, rewind, data and rejected words pass through latch, dispatch and push
// begin adds an eviction check that reads the oldest header for each evicted record,
// then the header writes; read walks the headers, fetches the byte it returns, and
// stops early on an empty record; every read goes through the single registered read port
// reset is asynchronous and needs no clearing pass; store contents start undefined
// a stalled output holds the finished word and the sequencer waits to push
`default_nettype none

module record_ring_buffer_with_eviction
  import rrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rrb_in_if.sink     in_i,
  rrb_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [1:0] cfg_data_i
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // sequencer: one state per memory access step
  rrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // store, pointers, walk and result registers
  rrb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (in_i.cmd),
    .in_level_i   (in_i.level),
    .in_length_i  (in_i.record_length),
    .in_byte_i    (in_i.data_byte),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_byte_o   (out_o.out_byte),
    .out_level_o  (out_o.out_level),
    .out_last_o   (out_o.last_of_record)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rrb_checker.sv =====
// rrb_checker: port-level assertions for the record ring buffer, with bind
// depends on rrb_pkg
`default_nettype none

module rrb_checker
  import rrb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] out_level_i,
  input logic       last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(out_byte_i) && $stable(last_i))
    else $error("stalled word changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while one is in work");

  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NONE || status_i == ST_REJ)
      |-> out_byte_i == 8'd0 && out_level_i == 2'd0 && !last_i)
    else $error("payload on a word with no byte");

  a_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> last_i && out_byte_i == 8'd0)
    else $error("empty record word malformed");

endmodule

bind record_ring_buffer_with_eviction rrb_checker u_rrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .out_byte_i  (out_o.out_byte),
  .out_level_i (out_o.out_level),
  .last_i      (out_o.last_of_record)
);

`default_nettype wire

// ===== bench/tb_record_ring_buffer_with_eviction.sv =====
// tb_record_ring_buffer_with_eviction: self-checking bench for the record ring buffer,
// a directed table, random record traffic and an eviction run, checked against an internal predictor
// depends on rrb_pkg, rrb_in_if, rrb_out_if and record_ring_buffer_with_eviction
`timescale 1ns / 100ps

module tb_record_ring_buffer_with_eviction;
  import rrb_pkg::*;

  localparam int IDLE_LIMIT = 40000;  // cycles with no word moving before giving up
  localparam int HOLD_CYCLES = 400;   // long output stall to back up the input

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_b;
    logic [1:0] lvl;
    logic       last;
  } word_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [1:0]  lvl;
    logic [15:0] len;
    logic [7:0]  data_b;
    bit          typed;
    word_t       want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_addr_i;
  logic [1:0] cfg_data_i;

  rrb_in_if  in_if ();
  rrb_out_if out_if ();

  record_ring_buffer_with_eviction DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  word_t expected_words[$];   // results still owed by the block, oldest first
  int    mismatches = 0;
  int    words_sent = 0;
  int    snd_idle_pct = 0;    // chance of a sender gap before a word
  int    rcv_stall_pct = 0;   // chance of ready low on a cycle
  bit    hold_go = 0;         // request a long receiver hold-off
  int    hold_left = 0;

  // idling pattern and filter setting of each random phase
  int    idle_mode [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{10, 10}};
  int    filt [6][2] = '{'{3, 0}, '{0, 0}, '{2, 1}, '{3, 1}, '{1, 0}, '{0, 1}};

  // ---------------------------------------------------------------------------
  // predictor: shadow copy of ring, pointers, walk and filter settings
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_ring [BUF_BYTES];
  int unsigned oldest_at, newest_at, free_cnt, write_left, open_cnt;
  int unsigned walk_at, walk_left, walk_used;
  bit          rec_open, walk_inside;
  logic [1:0]  walk_lvl;
  logic [1:0]  flt_min_level;
  bit          flt_cumulative;

  function automatic int unsigned wrap_add(int unsigned p, int unsigned n);
    return (p + n) % BUF_BYTES;
  endfunction

  function automatic int unsigned stored_len(int unsigned p);
    return {16'd0, shadow_ring[wrap_add(p, 2)], shadow_ring[wrap_add(p, 1)]};
  endfunction

  function automatic bit level_shown(logic [1:0] l);
    return (flt_cumulative && l >= flt_min_level) || l == flt_min_level;
  endfunction

  task automatic push_byte(logic [7:0] b);
    shadow_ring[newest_at] = b;
    newest_at = wrap_add(newest_at, 1);
    if (free_cnt > 0) free_cnt--;
  endtask

  task automatic walk_restart();
    walk_at = oldest_at;
    walk_used = 0;
    walk_left = 0;
    walk_inside = 0;
    walk_lvl = '0;
  endtask

  task automatic ring_empty();
    oldest_at = 0;
    newest_at = 0;
    free_cnt = BUF_BYTES;
    write_left = 0;
    rec_open = 0;
    open_cnt = 0;
    walk_restart();
  endtask

  // works out the one result word of an accepted command and updates the shadow
  task automatic predict_word(input logic [2:0] cmd, input logic [1:0] lvl,
                              input logic [15:0] len_in, input logic [7:0] d,
                              output word_t res);
    int unsigned len, span, limit, hlen;
    logic [1:0] hl;
    bit evicted;
    res = '0;
    case (cmd)
      CMD_BEGIN: begin
        if (rec_open) begin
          res.status = ST_REJ;
        end else begin
          len = (len_in > LEN_CAP) ? LEN_CAP : len_in;
          evicted = 0;
          // drop the oldest records until header plus text fit
          while (free_cnt < len + 3 && free_cnt < BUF_BYTES) begin
            span = 3 + stored_len(oldest_at);
            evicted = 1;
            if (span > BUF_BYTES - free_cnt) begin
              oldest_at = newest_at;
              free_cnt = BUF_BYTES;
            end else begin
              oldest_at = wrap_add(oldest_at, span);
              free_cnt += span;
            end
          end
          if (evicted) walk_restart();
          push_byte({6'd0, lvl});
          push_byte(len[7:0]);
          push_byte(len[15:8]);
          write_left = len;
          rec_open = (len > 0);
          open_cnt = rec_open ? 3 : 0;
        end
      end
      CMD_DATA: begin
        if (!rec_open) begin
          res.status = ST_REJ;
        end else begin
          push_byte(d);
          open_cnt++;
          write_left--;
          if (write_left == 0) begin
            rec_open = 0;
            open_cnt = 0;
          end
        end
      end
      CMD_READ: begin
        // committed bytes: everything stored minus the open record
        limit = BUF_BYTES - free_cnt;
        if (rec_open) limit = (open_cnt < limit) ? limit - open_cnt : 0;
        res.status = ST_NONE;
        while (!walk_inside && walk_used + 3 <= limit) begin
          hl = shadow_ring[walk_at][1:0];
          hlen = stored_len(walk_at);
          walk_at = wrap_add(walk_at, 3);
          walk_used += 3;
          if (hlen > limit - walk_used) hlen = limit - walk_used;
          if (level_shown(hl)) begin
            if (hlen == 0) begin
              res.status = ST_EMPTY;
              res.lvl = hl;
              res.last = 1;
              break;
            end
            walk_inside = 1;
            walk_left = hlen;
            walk_lvl = hl;
          end else begin
            walk_at = wrap_add(walk_at, hlen);
            walk_used += hlen;
          end
        end
        if (walk_inside) begin
          res.status = ST_OK;
          res.data_b = shadow_ring[walk_at];
          res.lvl = walk_lvl;
          walk_at = wrap_add(walk_at, 1);
          walk_used++;
          walk_left--;
          if (walk_left == 0) begin
            walk_inside = 0;
            res.last = 1;
          end
        end
      end
      CMD_CLEAR:  ring_empty();
      CMD_REWIND: walk_restart();
      default:    res.status = ST_REJ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results owed",
               quiet_cycles, expected_words.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random ready, long hold-off on request, compare with oldest word
  // ---------------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %0h, expected %0h (word %0d)", what, got, want, words_sent);
  endtask

  always @(posedge clk_i) begin
    word_t w;
    if (out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", int'(out_if.status), 0);
      end else begin
        w = expected_words.pop_front();
        if (out_if.status !== w.status)
          report("status", int'(out_if.status), int'(w.status));
        if (out_if.out_byte !== w.data_b)
          report("out_byte", int'(out_if.out_byte), int'(w.data_b));
        if (out_if.out_level !== w.lvl)
          report("out_level", int'(out_if.out_level), int'(w.lvl));
        if (out_if.last_of_record !== w.last)
          report("last_of_record", int'(out_if.last_of_record), int'(w.last));
      end
    end
    // hold-off counted here so the sender keeps offering words meanwhile
    if (hold_go && hold_left == 0) begin
      hold_go = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  // offers one word, waits for it to be taken, then records what it must return
  task automatic send_word(logic [2:0] cmd, logic [1:0] lvl, logic [15:0] len,
                           logic [7:0] d, bit typed = 0, word_t want = '0);
    word_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.level <= lvl;
    in_if.record_length <= len;
    in_if.data_byte <= d;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(cmd, lvl, len, d, res);
    expected_words.push_back(typed ? want : res);
    words_sent++;
  endtask

  // lets every owed result come back, then waits for the sequencer to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // registers only change while nothing is in flight
  task automatic set_filter(logic [1:0] min_lvl, bit cumul);
    drain();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_MIN_LEVEL;
    cfg_data_i <= min_lvl;
    @(posedge clk_i);
    cfg_addr_i <= CFG_CUMULATIVE;
    cfg_data_i <= {1'b0, cumul};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    flt_min_level = min_lvl;
    flt_cumulative = cumul;
  endtask

  // one well-formed record with reads and some noise mixed into its text
  task automatic random_record(int unsigned max_len);
    int unsigned len, n, k;
    logic [2:0] junk;
    k = $urandom_range(99);
    if (k < 60)      len = $urandom_range(0, 12);
    else if (k < 93) len = $urandom_range(13, 60);
    else             len = $urandom_range(0, max_len);
    send_word(CMD_BEGIN, 2'($urandom_range(0, 3)), 16'(len), 8'($urandom));
    n = (len > LEN_CAP) ? LEN_CAP : len;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(999);
      if (k < 200) begin
        send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
      end else if (k < 215) begin
        // stray words: rewind, unknown codes, begin while open
        junk = 3'($urandom_range(0, 2));
        junk = (junk == 3'd0) ? CMD_BEGIN : 3'($urandom_range(CMD_REWIND, 7));
        send_word(junk, 2'($urandom), 16'($urandom), 8'($urandom));
      end else if (k < 218) begin
        send_word(CMD_CLEAR, 2'($urandom), 16'($urandom), 8'($urandom));
        return;
      end
      send_word(CMD_DATA, 2'($urandom), 16'($urandom), 8'($urandom));
    end
    n = $urandom_range(0, 6);
    repeat (n) send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
    if ($urandom_range(99) < 4)
      send_word(CMD_DATA, 2'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // directed table: typed answers where they are plain, predictor elsewhere
  row_t table_rows[] = '{
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_NONE, 8'h00, 2'd0, 1'b0}},
    '{CMD_DATA,   2'd3, 16'hffff, 8'hff, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{3'd5,       2'd0, 16'h0000, 8'h00, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{3'd6,       2'd1, 16'h1234, 8'h5a, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{3'd7,       2'd3, 16'hffff, 8'hff, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{CMD_BEGIN,  2'd3, 16'h0000, 8'h00, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_EMPTY, 8'h00, 2'd3, 1'b1}},
    '{CMD_BEGIN,  2'd1, 16'h0002, 8'h00, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_DATA,   2'd0, 16'h0000, 8'hff, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_DATA,   2'd0, 16'h0000, 8'h00, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_OK,   8'hff, 2'd1, 1'b0}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_OK,   8'h00, 2'd1, 1'b1}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_NONE, 8'h00, 2'd0, 1'b0}},
    '{CMD_BEGIN,  2'd2, 16'hffff, 8'h00, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_BEGIN,  2'd0, 16'h0001, 8'h00, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_NONE, 8'h00, 2'd0, 1'b0}},
    '{CMD_DATA,   2'd0, 16'h0000, 8'h55, 0, '0},
    '{CMD_REWIND, 2'd0, 16'h0000, 8'h00, 0, '0},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 0, '0},
    '{CMD_CLEAR,  2'd0, 16'h0000, 8'h00, 1, '{ST_OK,   8'h00, 2'd0, 1'b0}},
    '{CMD_DATA,   2'd0, 16'h0000, 8'haa, 1, '{ST_REJ,  8'h00, 2'd0, 1'b0}},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1, '{ST_NONE, 8'h00, 2'd0, 1'b0}},
    '{CMD_BEGIN,  2'd0, 16'h0001, 8'h00, 0, '0},
    '{CMD_DATA,   2'd0, 16'h0000, 8'ha5, 0, '0},
    '{CMD_READ,   2'd0, 16'h0000, 8'h00, 0, '0}
  };

  initial begin
    int target;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_MIN_LEVEL;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_READ;
    in_if.level = '0;
    in_if.record_length = '0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < BUF_BYTES; i++) shadow_ring[i] = '0;
    flt_min_level = 2'd0;
    flt_cumulative = 1'b1;
    ring_empty();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs with the reset filter
    foreach (table_rows[i])
      send_word(table_rows[i].cmd, table_rows[i].lvl, table_rows[i].len,
                table_rows[i].data_b, table_rows[i].typed, table_rows[i].want);

    // random records, one idling pattern and filter setting per phase
    for (int ph = 0; ph < 6; ph++) begin
      set_filter(2'(filt[ph][0]), filt[ph][1] != 0);
      snd_idle_pct = idle_mode[ph % 4][0];
      rcv_stall_pct = idle_mode[ph % 4][1];
      if (ph == 1) hold_go = 1;  // output held off while the input backs up
      target = words_sent + 40;
      while (words_sent < target) random_record(120);
    end

    // empty records fill the ring until the oldest must go, then a longer
    // record evicts a whole run of them at once
    set_filter(2'd0, 1'b1);
    snd_idle_pct = 0;
    rcv_stall_pct = 10;
    while (free_cnt >= 3)
      send_word(CMD_BEGIN, 2'($urandom), 16'd0, 8'($urandom));
    repeat (6) begin
      send_word(CMD_BEGIN, 2'($urandom), 16'd0, 8'($urandom));
      send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
    end
    send_word(CMD_BEGIN, 2'($urandom), 16'($urandom_range(40, 80)), 8'($urandom));
    while (rec_open) begin
      if ($urandom_range(99) < 15)
        send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
      send_word(CMD_DATA, 2'($urandom), 16'($urandom), 8'($urandom));
    end
    repeat (8) send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
    set_filter(2'd3, 1'b0);
    repeat (20) send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
    send_word(CMD_REWIND, 2'($urandom), 16'($urandom), 8'($urandom));
    repeat (20) send_word(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rrb_pkg.sv
rtl/core/rrb_if.sv
rtl/core/rrb_ctrl.sv
rtl/core/rrb_dpath.sv
rtl/core/record_ring_buffer_with_eviction.sv
rtl/core/rrb_checker.sv
bench/tb_record_ring_buffer_with_eviction.sv
